// File: rtl/lidar_sector_steering_unit_assert.svh
// Assertion macros for the lidar sector steering unit checker.
// Needs nothing else; included by the checker file alone.
`ifndef LIDAR_SECTOR_STEERING_UNIT_ASSERT_SVH
`define LIDAR_SECTOR_STEERING_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define LSSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define LSSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lss_pkg.sv
// Shared types and constants of the lidar sector steering unit.
// No dependencies; used by lss_engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

   // field widths
   localparam int DistW   = 16;
   localparam int IdxW    = 12;
   localparam int DegW    = 8;
   localparam int UnitW   = 4;
   localparam int ModeW   = 3;
   localparam int QW      = 24;   // Q16.8 avoid distance
   localparam int NumW    = 40;   // engine numerator / product
   localparam int CntW    = 6;
   localparam int AngleW  = 10;
   localparam int MagW    = 9;
   localparam int BoundW  = 14;   // signed window bound
   localparam int CsrAW   = 3;
   localparam int ReqDW   = 40;
   localparam int RspDW   = 80;

   // avoid modes
   localparam logic [ModeW-1:0] MODE_NORMAL      = 3'd0;
   localparam logic [ModeW-1:0] MODE_CUT_LEFT    = 3'd1;
   localparam logic [ModeW-1:0] MODE_CUT_RIGHT   = 3'd2;
   localparam logic [ModeW-1:0] MODE_FORCE_LEFT  = 3'd3;
   localparam logic [ModeW-1:0] MODE_FORCE_RIGHT = 3'd4;
   localparam logic [ModeW-1:0] MODE_SLOW        = 3'd5;

   // register indexes
   localparam logic [CsrAW-1:0] CSR_SCAN_LENGTH   = 3'd0;
   localparam logic [CsrAW-1:0] CSR_FRONT_DEGREE  = 3'd1;
   localparam logic [CsrAW-1:0] CSR_SIDE_DEGREE   = 3'd2;
   localparam logic [CsrAW-1:0] CSR_AVOID_DEGREE  = 3'd3;
   localparam logic [CsrAW-1:0] CSR_MAX_RANGE     = 3'd4;
   localparam logic [CsrAW-1:0] CSR_STEER_GAIN    = 3'd5;
   localparam logic [CsrAW-1:0] CSR_CUT_OFF_RATIO = 3'd6;
   localparam logic [CsrAW-1:0] CSR_SIDE_DISTANCE = 3'd7;

   // register reset values
   localparam logic [IdxW-1:0]  RST_SCAN_LENGTH   = 12'd720;
   localparam logic [UnitW-1:0] RST_UNIT          = 4'd2;
   localparam logic [DegW-1:0]  RST_FRONT_DEGREE  = 8'd10;
   localparam logic [DegW-1:0]  RST_SIDE_DEGREE   = 8'd90;
   localparam logic [DegW-1:0]  RST_AVOID_DEGREE  = 8'd60;
   localparam logic [DistW-1:0] RST_MAX_RANGE     = 16'd5000;
   localparam logic [DistW-1:0] RST_STEER_GAIN    = 16'd256;
   localparam logic [DistW-1:0] RST_CUT_OFF_RATIO = 16'd512;
   localparam logic [DistW-1:0] RST_SIDE_DISTANCE = 16'd1000;

   // floor(n/360) as (n * UNIT_RECIP) >> UNIT_SHIFT, exact for 12-bit n
   localparam logic [12:0] UNIT_RECIP = 13'd5826;
   localparam int          UNIT_SHIFT = 21;
   localparam int          UnitProdW  = 25;

   // sample gate
   localparam logic [DistW-1:0] MIN_INTENSITY = 16'd10;
   localparam logic [DistW-1:0] MIN_RANGE     = 16'd10;

   // steering arithmetic
   localparam logic [MagW-1:0]  ANGLE_LIMIT  = 9'd480;
   localparam logic [DistW-1:0] MRAD_SCALE   = 16'd1000;
   localparam logic [QW-1:0]    Q24_MAX      = 24'hFF_FFFF;
   localparam logic [QW:0]      RATIO_ONE    = 25'h001_0000;
   localparam logic [NumW-1:0]  RATIO_LIMIT  = 40'h00_0101_0000;  // 2^24 + 2^16
   localparam logic [DistW-1:0] WIN_EMPTY    = 16'hFFFF;

   // engine operations and step counts
   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;
   localparam logic [CntW-1:0] DIV_STEPS = 6'd40;
   localparam logic [CntW-1:0] MUL_STEPS = 6'd16;

   typedef struct packed {
      logic            start;
      logic            op;
      logic [NumW-1:0] num;    // dividend, or multiplier in the low 16 bits
      logic [QW-1:0]   opnd;   // divisor or multiplicand
   } eng_cmd_type;

   typedef struct packed {
      logic            busy;
      logic            done;
      logic [NumW-1:0] result; // quotient or product
   } eng_stat_type;

endpackage

`default_nettype wire

// File: rtl/lidar_sector_steering_unit.sv
// Lidar sector steering unit: window minima per sample, steering angle per scan.
// Depends on lss_pkg and lss_engine.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  req     | in        | tvalid/tready/tlast | tdata: range_mm, intensity, avoid_mode
//  rsp     | out       | tvalid/tready       | tdata: four distances, angle, slow flag
//  csr     | in        | we (no wait)        | addr: register index, wdata: value
//
//  A sample that is not last in its scan is taken without a stall; req_tready stays high.
//  A last sample holds req_tready low while the sequencer runs the shared lss_engine
//  (one bit a cycle) for at most two divides and two multiplies, and longer while
//  the previous result still waits.
//  Reset is synchronous and active high; it restores the register defaults.
//  A waiting result does not stall plain samples; only the next last sample waits.
`timescale 1ns / 1ps
`default_nettype none

module lidar_sector_steering_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req_tdata from bit 0: range_mm[15:0], intensity[15:0], avoid_mode[2:0], zero pad
   input  wire logic                        req_tvalid,
   output      logic                        req_tready,
   input  wire logic [lss_pkg::ReqDW-1:0]   req_tdata,
   input  wire logic                        req_tlast,
   // rsp_tdata from bit 0: front_left, front_right, side_left, side_right (16 each),
   // steer_angle[9:0] signed, slow_down, zero pad
   output      logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   output      logic [lss_pkg::RspDW-1:0]   rsp_tdata,
   input  wire logic                        csr_we,
   input  wire logic [lss_pkg::CsrAW-1:0]   csr_addr,
   input  wire logic [lss_pkg::DistW-1:0]   csr_wdata
);

   // sequencer codes
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_PREP      = 3'd1;
   localparam logic [2:0] S_DIV_CUT   = 3'd2;
   localparam logic [2:0] S_RATIO     = 3'd3;
   localparam logic [2:0] S_DIV_RATIO = 3'd4;
   localparam logic [2:0] S_MUL_GAIN  = 3'd5;
   localparam logic [2:0] S_MUL_SCALE = 3'd6;
   localparam logic [2:0] S_FINISH    = 3'd7;

   localparam int NumWin = 6;
   // window order: front left/right, side left/right, avoid left/right
   localparam int W_FL = 0;
   localparam int W_FR = 1;
   localparam int W_SL = 2;
   localparam int W_SR = 3;
   localparam int W_AL = 4;
   localparam int W_AR = 5;

   function automatic logic [lss_pkg::DistW-1:0] clip_dist(
      input logic [lss_pkg::DistW-1:0] d,
      input logic [lss_pkg::DistW-1:0] lim
   );
      return (d < lim) ? d : lim;
   endfunction

   // configuration registers
   logic [lss_pkg::IdxW-1:0]   scan_length_ff, scan_length_in;
   logic [lss_pkg::UnitW-1:0]  unit_ff, unit_in;
   logic [lss_pkg::DegW-1:0]   front_deg_ff, front_deg_in;
   logic [lss_pkg::DegW-1:0]   side_deg_ff, side_deg_in;
   logic [lss_pkg::DegW-1:0]   avoid_deg_ff, avoid_deg_in;
   logic [lss_pkg::DistW-1:0]  max_range_ff, max_range_in;
   logic [lss_pkg::DistW-1:0]  steer_gain_ff, steer_gain_in;
   logic [lss_pkg::DistW-1:0]  cut_ratio_ff, cut_ratio_in;
   logic [lss_pkg::DistW-1:0]  side_dist_ff, side_dist_in;

   // scan state
   logic [lss_pkg::IdxW-1:0]   sample_index_ff, sample_index_in;
   logic [lss_pkg::DistW-1:0]  win_min_ff [NumWin];
   logic [lss_pkg::DistW-1:0]  win_min_in [NumWin];

   // end-of-scan sequencer
   logic [2:0]                 state_ff, state_in;
   logic [lss_pkg::ModeW-1:0]  mode_ff, mode_in;
   logic [lss_pkg::QW-1:0]     left_ff, left_in;
   logic [lss_pkg::QW-1:0]     right_ff, right_in;
   logic                       neg_ff, neg_in;
   logic [lss_pkg::MagW-1:0]   mag_ff, mag_in;
   logic [lss_pkg::DistW-1:0]  out_fl_ff, out_fl_in;
   logic [lss_pkg::DistW-1:0]  out_fr_ff, out_fr_in;
   logic [lss_pkg::DistW-1:0]  out_sl_ff, out_sl_in;
   logic [lss_pkg::DistW-1:0]  out_sr_ff, out_sr_in;
   logic                       slow_ff, slow_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lss_pkg::RspDW-1:0]  rsp_data_ff, rsp_data_in;

   lss_pkg::eng_cmd_type       eng_cmd;
   lss_pkg::eng_stat_type      eng_stat;

   // request fields
   logic [lss_pkg::DistW-1:0]  range_mm;
   logic [lss_pkg::DistW-1:0]  intensity;
   logic [lss_pkg::ModeW-1:0]  avoid_mode;
   logic                       req_xfer;
   logic                       sample_ok;

   // window bounds
   logic [lss_pkg::IdxW-1:0]          f_idx, s_idx, a_idx;
   logic signed [lss_pkg::BoundW-1:0] n_s, f_s, s_s, a_s, i_s;
   logic signed [lss_pkg::BoundW-1:0] win_lo [NumWin];
   logic signed [lss_pkg::BoundW-1:0] win_hi [NumWin];

   // csr helpers and steering temporaries
   logic [lss_pkg::UnitProdW-1:0]     unit_prod;
   logic [lss_pkg::DistW-1:0]         clip_al, clip_ar;
   logic [lss_pkg::QW-1:0]            big, small_q, quo_sat;
   logic [lss_pkg::QW:0]              ratio_excess;
   logic [lss_pkg::DistW-1:0]         scaled_mag;
   logic [lss_pkg::AngleW-1:0]        angle;
   logic                              neg_now;

   lss_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (eng_cmd),
      .stat  (eng_stat)
   );

   assign range_mm   = req_tdata[15:0];
   assign intensity  = req_tdata[31:16];
   assign avoid_mode = req_tdata[34:32];

   // accept samples only while the sequencer rests
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign sample_ok  = (intensity >= lss_pkg::MIN_INTENSITY) && (range_mm > lss_pkg::MIN_RANGE);

   // window edges in samples: unit * degrees, unit is held ready since the csr write
   assign f_idx = {8'd0, unit_ff} * {4'd0, front_deg_ff};
   assign s_idx = {8'd0, unit_ff} * {4'd0, side_deg_ff};
   assign a_idx = {8'd0, unit_ff} * {4'd0, avoid_deg_ff};
   assign n_s   = $signed({2'b00, scan_length_ff});
   assign f_s   = $signed({2'b00, f_idx});
   assign s_s   = $signed({2'b00, s_idx});
   assign a_s   = $signed({2'b00, a_idx});
   assign i_s   = $signed({2'b00, sample_index_ff});

   always_comb begin
      win_lo[W_FL] = n_s - f_s;    win_hi[W_FL] = n_s - 14'sd1;
      win_lo[W_FR] = '0;           win_hi[W_FR] = f_s;
      win_lo[W_SL] = n_s - s_s;    win_hi[W_SL] = n_s - f_s;
      win_lo[W_SR] = f_s;          win_hi[W_SR] = s_s;
      win_lo[W_AL] = n_s - a_s;    win_hi[W_AL] = n_s - f_s;
      win_lo[W_AR] = f_s;          win_hi[W_AR] = a_s;
   end

   // floor(scan_length / 360) by reciprocal, taken at the write itself
   assign unit_prod = {13'd0, csr_wdata[lss_pkg::IdxW-1:0]} * {12'd0, lss_pkg::UNIT_RECIP};

   assign clip_al = clip_dist(win_min_ff[W_AL], max_range_ff);
   assign clip_ar = clip_dist(win_min_ff[W_AR], max_range_ff);

   // ratio operands: the larger avoid distance over the smaller, left wins ties
   assign neg_now = (left_ff >= right_ff);
   assign big     = neg_now ? left_ff : right_ff;
   assign small_q = neg_now ? right_ff : left_ff;

   assign quo_sat      = (|eng_stat.result[lss_pkg::NumW-1:lss_pkg::QW]) ?
                         lss_pkg::Q24_MAX : eng_stat.result[lss_pkg::QW-1:0];
   assign ratio_excess = eng_stat.result[lss_pkg::QW:0] - lss_pkg::RATIO_ONE;
   assign scaled_mag   = eng_stat.result[lss_pkg::NumW-1:lss_pkg::QW];
   assign angle        = neg_ff ? (10'd0 - {1'b0, mag_ff}) : {1'b0, mag_ff};

   // configuration writes
   always_comb begin
      scan_length_in = scan_length_ff;
      unit_in        = unit_ff;
      front_deg_in   = front_deg_ff;
      side_deg_in    = side_deg_ff;
      avoid_deg_in   = avoid_deg_ff;
      max_range_in   = max_range_ff;
      steer_gain_in  = steer_gain_ff;
      cut_ratio_in   = cut_ratio_ff;
      side_dist_in   = side_dist_ff;
      if (csr_we) begin
         unique case (csr_addr)
            lss_pkg::CSR_SCAN_LENGTH: begin
               scan_length_in = csr_wdata[lss_pkg::IdxW-1:0];
               unit_in        = unit_prod[lss_pkg::UNIT_SHIFT +: lss_pkg::UnitW];
            end
            lss_pkg::CSR_FRONT_DEGREE:  front_deg_in  = csr_wdata[lss_pkg::DegW-1:0];
            lss_pkg::CSR_SIDE_DEGREE:   side_deg_in   = csr_wdata[lss_pkg::DegW-1:0];
            lss_pkg::CSR_AVOID_DEGREE:  avoid_deg_in  = csr_wdata[lss_pkg::DegW-1:0];
            lss_pkg::CSR_MAX_RANGE:     max_range_in  = csr_wdata;
            lss_pkg::CSR_STEER_GAIN:    steer_gain_in = csr_wdata;
            lss_pkg::CSR_CUT_OFF_RATIO: cut_ratio_in  = csr_wdata;
            lss_pkg::CSR_SIDE_DISTANCE: side_dist_in  = csr_wdata;
         endcase
      end
   end

   // sample path and end-of-scan sequencer
   always_comb begin
      sample_index_in = sample_index_ff;
      for (int k = 0; k < NumWin; k++) begin
         win_min_in[k] = win_min_ff[k];
      end
      state_in     = state_ff;
      mode_in      = mode_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      out_fl_in    = out_fl_ff;
      out_fr_in    = out_fr_ff;
      out_sl_in    = out_sl_ff;
      out_sr_in    = out_sr_ff;
      slow_in      = slow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      eng_cmd      = '0;

      // drop the result once the consumer has taken it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // fold the sample into every window that holds its index
               for (int k = 0; k < NumWin; k++) begin
                  if (sample_ok && (i_s >= win_lo[k]) && (i_s <= win_hi[k]) &&
                      (range_mm < win_min_ff[k])) begin
                     win_min_in[k] = range_mm;
                  end
               end
               if (req_tlast) begin
                  sample_index_in = '0;
                  mode_in         = avoid_mode;
                  state_in        = S_PREP;
               end else begin
                  sample_index_in = sample_index_ff + 1'b1;
               end
            end
         end

         S_PREP: begin
            // capture clipped distances, reload the minima for the next scan
            out_fl_in = clip_dist(win_min_ff[W_FL], max_range_ff);
            out_fr_in = clip_dist(win_min_ff[W_FR], max_range_ff);
            out_sl_in = clip_dist(win_min_ff[W_SL], max_range_ff);
            out_sr_in = clip_dist(win_min_ff[W_SR], max_range_ff);
            slow_in   = (mode_ff == lss_pkg::MODE_SLOW);
            for (int k = 0; k < NumWin; k++) begin
               win_min_in[k] = lss_pkg::WIN_EMPTY;
            end
            left_in  = {clip_al, 8'd0};
            right_in = {clip_ar, 8'd0};
            state_in = S_RATIO;
            // the other modes leave both avoid distances as they are
            if (mode_ff == lss_pkg::MODE_CUT_LEFT ||
                mode_ff == lss_pkg::MODE_CUT_RIGHT) begin
               if (cut_ratio_ff == '0) begin
                  // zero cut-off ratio saturates the divided side
                  if (mode_ff == lss_pkg::MODE_CUT_LEFT) begin
                     left_in = lss_pkg::Q24_MAX;
                  end else begin
                     right_in = lss_pkg::Q24_MAX;
                  end
               end else begin
                  eng_cmd.start = 1'b1;
                  eng_cmd.op    = lss_pkg::OP_DIV;
                  eng_cmd.num   = (mode_ff == lss_pkg::MODE_CUT_LEFT) ?
                                  {8'd0, clip_al, 16'd0} : {8'd0, clip_ar, 16'd0};
                  eng_cmd.opnd  = {8'd0, cut_ratio_ff};
                  state_in      = S_DIV_CUT;
               end
            end else if (mode_ff == lss_pkg::MODE_FORCE_LEFT) begin
               left_in = {side_dist_ff, 8'd0};
            end else if (mode_ff == lss_pkg::MODE_FORCE_RIGHT) begin
               right_in = {side_dist_ff, 8'd0};
            end
         end

         S_DIV_CUT: begin
            if (eng_stat.done) begin
               if (mode_ff == lss_pkg::MODE_CUT_LEFT) begin
                  left_in = quo_sat;
               end else begin
                  right_in = quo_sat;
               end
               state_in = S_RATIO;
            end
         end

         S_RATIO: begin
            neg_in = neg_now;
            priority if (steer_gain_ff == '0) begin
               mag_in   = '0;
               state_in = S_FINISH;
            end else if (small_q == '0) begin
               mag_in   = lss_pkg::ANGLE_LIMIT;
               state_in = S_FINISH;
            end else begin
               eng_cmd.start = 1'b1;
               eng_cmd.op    = lss_pkg::OP_DIV;
               eng_cmd.num   = {big, 16'd0};
               eng_cmd.opnd  = small_q;
               state_in      = S_DIV_RATIO;
            end
         end

         S_DIV_RATIO: begin
            if (eng_stat.done) begin
               // any excess of 2^24 or more saturates once the gain is non-zero
               if (eng_stat.result >= lss_pkg::RATIO_LIMIT) begin
                  mag_in   = lss_pkg::ANGLE_LIMIT;
                  state_in = S_FINISH;
               end else begin
                  eng_cmd.start = 1'b1;
                  eng_cmd.op    = lss_pkg::OP_MUL;
                  eng_cmd.num   = {24'd0, steer_gain_ff};
                  eng_cmd.opnd  = ratio_excess[lss_pkg::QW-1:0];
                  state_in      = S_MUL_GAIN;
               end
            end
         end

         S_MUL_GAIN: begin
            if (eng_stat.done) begin
               // a product of 2^24 or more scales past the limit
               if (|eng_stat.result[lss_pkg::NumW-1:lss_pkg::QW]) begin
                  mag_in   = lss_pkg::ANGLE_LIMIT;
                  state_in = S_FINISH;
               end else begin
                  eng_cmd.start = 1'b1;
                  eng_cmd.op    = lss_pkg::OP_MUL;
                  eng_cmd.num   = {24'd0, lss_pkg::MRAD_SCALE};
                  eng_cmd.opnd  = eng_stat.result[lss_pkg::QW-1:0];
                  state_in      = S_MUL_SCALE;
               end
            end
         end

         S_MUL_SCALE: begin
            if (eng_stat.done) begin
               mag_in   = (scaled_mag > {7'd0, lss_pkg::ANGLE_LIMIT}) ?
                          lss_pkg::ANGLE_LIMIT : scaled_mag[lss_pkg::MagW-1:0];
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            // hold until the output register is free, then transfer
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, slow_ff, angle, out_sr_ff, out_sl_ff,
                               out_fr_ff, out_fl_ff};
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_length_ff  <= lss_pkg::RST_SCAN_LENGTH;
         unit_ff         <= lss_pkg::RST_UNIT;
         front_deg_ff    <= lss_pkg::RST_FRONT_DEGREE;
         side_deg_ff     <= lss_pkg::RST_SIDE_DEGREE;
         avoid_deg_ff    <= lss_pkg::RST_AVOID_DEGREE;
         max_range_ff    <= lss_pkg::RST_MAX_RANGE;
         steer_gain_ff   <= lss_pkg::RST_STEER_GAIN;
         cut_ratio_ff    <= lss_pkg::RST_CUT_OFF_RATIO;
         side_dist_ff    <= lss_pkg::RST_SIDE_DISTANCE;
         sample_index_ff <= '0;
         for (int k = 0; k < NumWin; k++) begin
            win_min_ff[k] <= lss_pkg::WIN_EMPTY;
         end
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         scan_length_ff  <= scan_length_in;
         unit_ff         <= unit_in;
         front_deg_ff    <= front_deg_in;
         side_deg_ff     <= side_deg_in;
         avoid_deg_ff    <= avoid_deg_in;
         max_range_ff    <= max_range_in;
         steer_gain_ff   <= steer_gain_in;
         cut_ratio_ff    <= cut_ratio_in;
         side_dist_ff    <= side_dist_in;
         sample_index_ff <= sample_index_in;
         for (int k = 0; k < NumWin; k++) begin
            win_min_ff[k] <= win_min_in[k];
         end
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      out_fl_ff   <= out_fl_in;
      out_fr_ff   <= out_fr_in;
      out_sl_ff   <= out_sl_in;
      out_sr_ff   <= out_sr_in;
      slow_ff     <= slow_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/lss_engine.sv
// Shared shift/add engine: restoring divide (40 steps) or shift-add multiply (16 steps).
// Depends on lss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lss_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lss_pkg::eng_cmd_type cmd,
   output lss_pkg::eng_stat_type     stat
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         op_ff, op_in;
   logic [lss_pkg::CntW-1:0]     cnt_ff, cnt_in;
   logic [lss_pkg::NumW-1:0]     hi_ff, hi_in;
   logic [lss_pkg::NumW-1:0]     lo_ff, lo_in;
   logic [lss_pkg::QW-1:0]       opnd_ff, opnd_in;

   logic [lss_pkg::NumW-1:0]     opx;
   logic [lss_pkg::NumW-1:0]     opy;
   logic [lss_pkg::NumW:0]       sum;

   // one adder/subtractor serves both operations
   always_comb begin
      if (op_ff == lss_pkg::OP_DIV) begin
         opx = {15'd0, hi_ff[lss_pkg::QW-1:0], lo_ff[lss_pkg::NumW-1]};
         opy = {16'd0, opnd_ff};
         sum = {1'b0, opx} - {1'b0, opy};
      end else begin
         opx = {hi_ff[lss_pkg::NumW-2:0], 1'b0};
         opy = lo_ff[lss_pkg::NumW-1] ? {16'd0, opnd_ff} : '0;
         sum = {1'b0, opx} + {1'b0, opy};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      opnd_in = opnd_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         opnd_in = cmd.opnd;
         hi_in   = '0;
         if (cmd.op == lss_pkg::OP_DIV) begin
            cnt_in = lss_pkg::DIV_STEPS;
            lo_in  = cmd.num;
         end else begin
            cnt_in = lss_pkg::MUL_STEPS;
            lo_in  = {cmd.num[15:0], 24'd0};
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == lss_pkg::OP_DIV) begin
            if (!sum[lss_pkg::NumW]) begin
               hi_in = {16'd0, sum[lss_pkg::QW-1:0]};
               lo_in = {lo_ff[lss_pkg::NumW-2:0], 1'b1};
            end else begin
               hi_in = {16'd0, opx[lss_pkg::QW-1:0]};
               lo_in = {lo_ff[lss_pkg::NumW-2:0], 1'b0};
            end
         end else begin
            hi_in = sum[lss_pkg::NumW-1:0];
            lo_in = {lo_ff[lss_pkg::NumW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff   <= op_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      opnd_ff <= opnd_in;
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign stat.result = (op_ff == lss_pkg::OP_DIV) ? lo_ff : hi_ff;

endmodule

`default_nettype wire

// File: rtl/lss_checker.sv
// Port-level checker for the lidar sector steering unit, bound to the top level.
// Depends on lidar_sector_steering_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_sector_steering_unit_assert.svh"

module lss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata
);

   // a stalled result stays offered
   `LSSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp_tvalid dropped while stalled")

   // a stalled result keeps its payload
   `LSSU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp_tdata changed while stalled")

   // the end of a scan starts the steering computation, which takes the input side
   `LSSU_ASSERT_NEXT(a_busy_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "req_tready high right after a last sample")

   // the steering angle stays inside its clamp
   `LSSU_ASSERT_NOW(a_angle_range, clock, reset, rsp_tvalid, ($signed(rsp_tdata[73:64]) >= -10'sd480) && ($signed(rsp_tdata[73:64]) <= 10'sd480), "steer_angle beyond 480 mrad")

endmodule

bind lidar_sector_steering_unit lss_checker u_lss_checker (.*);

`default_nettype wire
